// ----- design/pld_pkg.sv -----
// ----------------------------------------------------------------------------
// polynomial long division package
// shared types, codes and constants
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_LOAD_DIVIDEND = 2'd0,
    OP_LOAD_DIVISOR  = 2'd1,
    OP_DIVIDE        = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_QUOTIENT  = 2'd0,
    KIND_REMAINDER = 2'd1,
    KIND_ERROR     = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_CLEAR, ST_QLOAD, ST_QDIV, ST_UREAD, ST_UMUL,
    ST_UWRITE, ST_EMIT_Q, ST_EMIT_R, ST_ERROR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       clear;
    logic       lead_load;
    logic       q_start;
    logic       q_store;
    logic       u_read;
    logic       u_mul;
    logic       u_write;
    logic       emit_q;
    logic       emit_r;
    logic       emit_err;
    logic       emit_last;
  } pld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lead_zero;
    logic q_done;
  } pld_status_t;

endpackage

// ----- design/pld_datapath.sv -----
// ----------------------------------------------------------------------------
// polynomial long division datapath
// coefficient stores, restoring divider, multiply and subtract unit
// ----------------------------------------------------------------------------
module pld_datapath
  import pld_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IW = $clog2(MAX_TERMS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_en,
  input  logic              load_sel,
  input  logic [IW-1:0]     load_idx,
  input  logic [31:0]       load_val,
  input  logic [IW-1:0]     lead_idx,
  input  logic [IW-1:0]     clr_idx,
  input  logic              clr_keep,
  input  logic [IW-1:0]     top_idx,
  input  logic [IW-1:0]     q_idx,
  input  logic [IW-1:0]     d_idx,
  input  logic [IW-1:0]     pos_idx,
  input  logic [IW-1:0]     emit_idx,
  input  pld_cmd_t          cmd,
  output pld_status_t       status,
  output logic              strobe,
  output logic [1:0]        kind,
  output logic [3:0]        degree,
  output logic [31:0]       coefficient,
  output logic              saturated,
  output logic              last
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [31:0] dvd_mem [MAX_TERMS];
  logic [31:0] dvs_mem [MAX_TERMS];
  logic [31:0] rem_mem [MAX_TERMS];
  logic [31:0] quo_mem [MAX_TERMS];
  logic [MAX_TERMS-1:0] rem_sat;
  logic [MAX_TERMS-1:0] quo_sat;

  logic signed [31:0] lead;

  // divider state
  logic [NW-1:0] num;
  logic [32:0]   part;
  logic [31:0]   den;
  logic          q_neg;
  logic [CW-1:0] cnt;
  logic          busy_div;
  logic [33:0]   part_sh;
  logic [33:0]   part_sub;

  // update state
  logic signed [31:0] qv;
  logic signed [63:0] prod;
  logic signed [31:0] d_reg, r_reg;

  always_ff @(posedge clk) begin
    if (load_en) begin
      if (load_sel) dvs_mem[load_idx] <= load_val;
      else          dvd_mem[load_idx] <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lead_load) lead <= dvs_mem[lead_idx];
  end
  assign status.lead_zero = (lead == '0);

  // restoring division of |r * 2^F| by |lead|, one bit per cycle
  assign part_sh  = {part, num[NW-1]};
  assign part_sub = part_sh - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_div <= 1'b0;
    end else if (cmd.q_start) begin
      busy_div <= 1'b1;
    end else if (busy_div && cnt == CW'(NW - 1)) begin
      busy_div <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      num   <= {(rem_mem[top_idx][31] ? 32'(-rem_mem[top_idx]) : rem_mem[top_idx]),
                {FRAC_BITS{1'b0}}};
      part  <= '0;
      den   <= lead[31] ? 32'(-lead) : lead;
      q_neg <= rem_mem[top_idx][31] ^ lead[31];
      cnt   <= '0;
    end else if (busy_div) begin
      cnt <= cnt + 1'b1;
      if (!part_sub[33]) begin
        part <= part_sub[32:0];
        num  <= {num[NW-2:0], 1'b1};
      end else begin
        part <= part_sh[32:0];
        num  <= {num[NW-2:0], 1'b0};
      end
    end
  end
  assign status.q_done = !busy_div && !cmd.q_start;

  // signed quotient with saturation
  logic signed [NW:0] q_full;
  logic [31:0] q_clip;
  logic        q_flag;
  always_comb begin
    q_full = q_neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
    if (q_full > $signed((NW+1)'(32'h7fffffff))) begin
      q_clip = 32'h7fffffff; q_flag = 1'b1;
    end else if (q_full < -$signed((NW+1)'(33'h080000000))) begin
      q_clip = 32'h80000000; q_flag = 1'b1;
    end else begin
      q_clip = q_full[31:0]; q_flag = 1'b0;
    end
  end

  // update: r[pos] -= trunc(d[j] * q / 2^F)
  logic signed [63:0] p_div;
  logic signed [64:0] nv;
  logic [31:0] nv_clip;
  logic        nv_flag;
  always_comb begin
    p_div = (prod < 0) ? -((-prod) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
    nv = 65'(r_reg) - 65'(p_div);
    if (nv > 65'sh7fffffff) begin
      nv_clip = 32'h7fffffff; nv_flag = 1'b1;
    end else if (nv < -65'sh80000000) begin
      nv_clip = 32'h80000000; nv_flag = 1'b1;
    end else begin
      nv_clip = nv[31:0]; nv_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.u_read) begin
      d_reg <= dvs_mem[d_idx];
      r_reg <= rem_mem[pos_idx];
    end
    if (cmd.u_mul) prod <= d_reg * qv;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rem_mem[clr_idx] <= clr_keep ? dvd_mem[clr_idx] : '0;
      quo_mem[clr_idx] <= '0;
      rem_sat[clr_idx] <= 1'b0;
      quo_sat[clr_idx] <= 1'b0;
    end
    if (cmd.q_store) begin
      quo_mem[q_idx] <= q_clip;
      quo_sat[q_idx] <= q_flag;
      qv             <= q_clip;
    end
    if (cmd.u_write) begin
      rem_mem[pos_idx] <= nv_clip;
      if (nv_flag) rem_sat[pos_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_q | cmd.emit_r | cmd.emit_err;
    end
    last   <= cmd.emit_last;
    degree <= 4'(emit_idx);
    if (cmd.emit_err) begin
      kind <= KIND_ERROR; coefficient <= '0; saturated <= 1'b0;
    end else if (cmd.emit_q) begin
      kind <= KIND_QUOTIENT; coefficient <= quo_mem[emit_idx];
      saturated <= quo_sat[emit_idx];
    end else begin
      kind <= KIND_REMAINDER; coefficient <= rem_mem[emit_idx];
      saturated <= rem_sat[emit_idx];
    end
  end

endmodule

// ----- design/pld_control.sv -----
// ----------------------------------------------------------------------------
// polynomial long division controller
// sequences clear, quotient steps, updates and result emission
// ----------------------------------------------------------------------------
module pld_control
  import pld_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  localparam int IW = $clog2(MAX_TERMS),
  localparam int TW = $clog2(MAX_TERMS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [TW-1:0] n_in,
  input  logic [TW-1:0] m_in,
  input  pld_status_t   status,
  output pld_cmd_t      cmd,
  output logic          busy,
  output logic [IW-1:0] lead_idx,
  output logic [IW-1:0] clr_idx,
  output logic          clr_keep,
  output logic [IW-1:0] top_idx,
  output logic [IW-1:0] q_idx,
  output logic [IW-1:0] d_idx,
  output logic [IW-1:0] pos_idx,
  output logic [IW-1:0] emit_idx
);

  state_t state, state_next;
  logic [TW-1:0] n, m, t, t_next, j, j_next, i, i_next, qn, rn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n <= n_in;
      m <= m_in;
    end
    t <= t_next;
    j <= j_next;
    i <= i_next;
  end

  assign qn       = (n >= m) ? TW'(n - m + 1'b1) : TW'(1);
  assign rn       = TW'(m - 1'b1);
  assign lead_idx = IW'(m_in - 1'b1);
  assign clr_idx  = IW'(i);
  assign clr_keep = i < n;
  assign top_idx  = IW'(n - 1'b1 - t);
  assign q_idx    = IW'(n - m - t);
  assign d_idx    = IW'(j);
  assign pos_idx  = IW'(n - m - t + j);
  assign emit_idx = IW'(i);
  assign busy     = state != ST_IDLE;

  always_comb begin
    state_next = state;
    t_next = t;
    j_next = j;
    i_next = i;
    cmd = '0;
    cmd.lead_load = go;
    case (state)
      ST_IDLE: begin
        if (go) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        i_next = '0;
        state_next = status.lead_zero ? ST_ERROR : ST_CLEAR;
      end
      ST_ERROR: begin
        cmd.emit_err = 1'b1;
        cmd.emit_last = 1'b1;
        i_next = '0;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        i_next = i + 1'b1;
        if (i == TW'(MAX_TERMS - 1)) begin
          t_next = '0;
          i_next = '0;
          state_next = (n >= m) ? ST_QLOAD : ST_EMIT_Q;
        end
      end
      ST_QLOAD: begin
        cmd.q_start = 1'b1;
        state_next = ST_QDIV;
      end
      ST_QDIV: begin
        if (status.q_done) begin
          cmd.q_store = 1'b1;
          j_next = '0;
          state_next = ST_UREAD;
        end
      end
      ST_UREAD: begin
        cmd.u_read = 1'b1;
        state_next = ST_UMUL;
      end
      ST_UMUL: begin
        cmd.u_mul = 1'b1;
        state_next = ST_UWRITE;
      end
      ST_UWRITE: begin
        cmd.u_write = 1'b1;
        j_next = j + 1'b1;
        if (j == m - 1'b1) begin
          t_next = t + 1'b1;
          state_next = (t + 1'b1 == qn) ? ST_EMIT_Q : ST_QLOAD;
        end else begin
          state_next = ST_UREAD;
        end
      end
      ST_EMIT_Q: begin
        cmd.emit_q = 1'b1;
        cmd.emit_last = (i + 1'b1 == qn) && (rn == '0);
        i_next = i + 1'b1;
        if (i + 1'b1 == qn) begin
          i_next = '0;
          state_next = (rn == '0) ? ST_IDLE : ST_EMIT_R;
        end
      end
      ST_EMIT_R: begin
        cmd.emit_r = 1'b1;
        cmd.emit_last = (i + 1'b1 == rn);
        i_next = i + 1'b1;
        if (i + 1'b1 == rn) begin
          i_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/polynomial_long_division.sv -----
// ----------------------------------------------------------------------------
// polynomial long division
// Q16.16 schoolbook division of two coefficient stores
// ----------------------------------------------------------------------------
// Loads are accepted back to back while idle. A divide request raises busy
// from the next cycle for the run: a check of the divisor lead, a copy of
// the dividend into the working store, then per quotient coefficient the
// bit-serial restoring divide with its load and store, plus a read, multiply
// and subtract step per divisor term, then one emit step per result. A zero
// divisor lead gives one error result after the check. Each result leaves in
// the cycle after its emit step, so the final one appears in the first cycle
// with busy low. Results appear for one cycle each with strobe high and
// cannot be stalled.
module polynomial_long_division
  import pld_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  index,
  input  logic signed [31:0] value,
  input  logic [4:0]  dividend_terms,
  input  logic [4:0]  divisor_terms,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  degree,
  output logic signed [31:0] coefficient,
  output logic        saturated,
  output logic        last
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int TW = $clog2(MAX_TERMS + 1);

  pld_cmd_t    cmd;
  pld_status_t status;
  logic [IW-1:0] lead_idx, clr_idx, top_idx, q_idx, d_idx, pos_idx, emit_idx;
  logic          clr_keep;
  logic          accept, go, load_en;
  logic [TW-1:0] n_in, m_in;

  function automatic logic [TW-1:0] clamp(input logic [4:0] v);
    logic [5:0] w;
    w = {1'b0, v};
    if (w == '0) w = 6'd1;
    if (w > 6'(MAX_TERMS)) w = 6'(MAX_TERMS);
    return TW'(w);
  endfunction

  assign accept  = start && !busy;
  assign go      = accept && op == OP_DIVIDE;
  assign load_en = accept && (op == OP_LOAD_DIVIDEND || op == OP_LOAD_DIVISOR)
                   && 32'(index) < 32'(MAX_TERMS);
  assign n_in    = clamp(dividend_terms);
  assign m_in    = clamp(divisor_terms);

  pld_control #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk, .rst, .go, .n_in, .m_in, .status, .cmd, .busy,
    .lead_idx, .clr_idx, .clr_keep, .top_idx, .q_idx, .d_idx, .pos_idx,
    .emit_idx
  );

  pld_datapath #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .load_en, .load_sel(op == OP_LOAD_DIVISOR),
    .load_idx(IW'(index)), .load_val(value), .lead_idx, .clr_idx, .clr_keep,
    .top_idx, .q_idx, .d_idx, .pos_idx, .emit_idx, .cmd, .status,
    .strobe, .kind, .degree, .coefficient, .saturated, .last
  );

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_ERROR |-> last) else $error("error without last");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("result after last");
  a_busy_go: assert property (@(posedge clk) disable iff (rst)
    go |=> busy) else $error("divide not started");
`endif

endmodule
